FILE: rtl/gcw_pkg.sv
`timescale 1ns / 1ps
// gcw_pkg: item types, cost constants and the divider step for the gateway cost weigher
// depends on nothing; imported by gateway_cost_weigher
package gcw_pkg;

    localparam int unsigned DIV_W   = 55;   // dividend and quotient width
    localparam int unsigned DVS_W   = 32;   // divisor width
    localparam int unsigned REM_W   = 33;   // trial remainder width
    localparam int unsigned N_DIV   = 3;    // uplink, downlink, path term

    localparam logic [31:0] FULL_SPEED    = 32'd320000000;
    localparam logic [17:0] BW_SCALE      = 18'd1000;
    localparam logic [62:0] COST_INFINITE = {63{1'b1}};

    // register indexes
    localparam logic [2:0] REG_ETX_DIVIDER     = 3'd0;
    localparam logic [2:0] REG_WEIGHT_UPLINK   = 3'd1;
    localparam logic [2:0] REG_WEIGHT_DOWNLINK = 3'd2;
    localparam logic [2:0] REG_WEIGHT_PATH     = 3'd3;
    localparam logic [2:0] REG_PATH_COST_LIMIT = 3'd4;

    // result selection codes
    localparam logic [1:0] MODE_INF     = 2'd0;
    localparam logic [1:0] MODE_CLASSIC = 2'd1;
    localparam logic [1:0] MODE_RAW     = 2'd2;
    localparam logic [1:0] MODE_SUM     = 2'd3;

    typedef struct packed {
        logic        link_up;
        logic [31:0] route_cost;
        logic [31:0] uplink_bandwidth;
        logic [31:0] downlink_bandwidth;
    } t_in_item;

    typedef struct packed {
        logic [62:0] cost;
        logic        unreachable;
    } t_out_item;

    // payload of one divider pipeline stage
    typedef struct packed {
        logic [1:0]                         mode;
        logic [31:0]                        route_cost;
        logic [N_DIV-1:0][DVS_W-1:0]        dvs;
        logic [N_DIV-1:0][DVS_W-1:0]        rem;
        logic [N_DIV-1:0][DIV_W-1:0]        dq;   // dividend shifts out, quotient in
    } t_stage;

    // one restoring division bit for each of the three dividers
    function automatic t_stage div_step(input t_stage st);
        t_stage           res;
        logic [REM_W-1:0] trial;
        logic             qbit;
        res = st;
        for (int k = 0; k < N_DIV; k++) begin
            trial = {st.rem[k], st.dq[k][DIV_W-1]};
            qbit  = (trial >= {1'b0, st.dvs[k]});
            if (qbit) begin
                trial = trial - {1'b0, st.dvs[k]};
            end
            res.rem[k] = trial[DVS_W-1:0];
            res.dq[k]  = {st.dq[k][DIV_W-2:0], qbit};
        end
        return res;
    endfunction

endpackage

FILE: rtl/gateway_cost_weigher.sv
`timescale 1ns / 1ps
// gateway_cost_weigher: top level, config registers, 55-stage divider pipeline, output register
// depends on gcw_pkg
//
// Takes one gateway item per cycle, unless the output is stalled, and returns its 63-bit
// cost plus an unreachable flag. Each item passes an input register, 55 divider stages
// (one quotient bit per stage for the uplink, downlink and path quotients in
// parallel) and an output register. A stalled output holds the whole pipeline.
// Registers are written over the APB port and must only change while no item is in flight.
module gateway_cost_weigher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gcw_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gcw_pkg::t_out_item   o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import gcw_pkg::*;

    localparam int unsigned NSTG = DIV_W;

    logic [7:0]  r_etx_divider;
    logic [7:0]  r_weight_uplink;
    logic [7:0]  r_weight_downlink;
    logic [7:0]  r_weight_path;
    logic [31:0] r_path_cost_limit;

    t_stage      r_st  [0:NSTG];
    logic        r_vld [0:NSTG];
    t_stage      n_st0;
    t_out_item   r_out;
    t_out_item   n_out;
    logic        r_out_vld;
    logic        en;

    logic [2:0]  reg_idx;
    logic [17:0] du;
    logic [17:0] dd;
    logic [31:0] prod;
    logic [55:0] qsum;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etx_divider     <= 8'd0;
            r_weight_uplink   <= 8'd1;
            r_weight_downlink <= 8'd1;
            r_weight_path     <= 8'd1;
            r_path_cost_limit <= 32'd0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_ETX_DIVIDER:     r_etx_divider     <= pwdata[7:0];
                REG_WEIGHT_UPLINK:   r_weight_uplink   <= pwdata[7:0];
                REG_WEIGHT_DOWNLINK: r_weight_downlink <= pwdata[7:0];
                REG_WEIGHT_PATH:     r_weight_path     <= pwdata[7:0];
                REG_PATH_COST_LIMIT: r_path_cost_limit <= pwdata;
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb begin
        unique case (reg_idx)
            REG_ETX_DIVIDER:     prdata = {24'd0, r_etx_divider};
            REG_WEIGHT_UPLINK:   prdata = {24'd0, r_weight_uplink};
            REG_WEIGHT_DOWNLINK: prdata = {24'd0, r_weight_downlink};
            REG_WEIGHT_PATH:     prdata = {24'd0, r_weight_path};
            REG_PATH_COST_LIMIT: prdata = r_path_cost_limit;
            default:             prdata = 32'd0;
        endcase
    end

    // whole pipeline moves unless the output item is stalled
    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // item classification and dividend setup
    always_comb begin
        du   = BW_SCALE * {10'd0, r_weight_uplink};
        dd   = BW_SCALE * {10'd0, r_weight_downlink};
        prod = 32'(i_in_item.route_cost * {24'd0, r_weight_path});
        n_st0            = '0;
        n_st0.route_cost = i_in_item.route_cost;
        n_st0.dvs[0]     = i_in_item.uplink_bandwidth;
        n_st0.dvs[1]     = i_in_item.downlink_bandwidth;
        n_st0.dvs[2]     = {24'd0, r_etx_divider};
        n_st0.dq[0]      = DIV_W'({du, 23'd0});
        n_st0.dq[1]      = DIV_W'({dd, 23'd0});
        n_st0.dq[2]      = {prod, 23'd0};
        if (!i_in_item.link_up) begin
            n_st0.mode = MODE_INF;
        end else if (r_etx_divider == 8'd0) begin
            n_st0.mode = MODE_CLASSIC;
        end else if (i_in_item.uplink_bandwidth == 32'd0 ||
                     i_in_item.downlink_bandwidth == 32'd0) begin
            n_st0.mode = MODE_INF;
        end else if (i_in_item.uplink_bandwidth >= FULL_SPEED &&
                     i_in_item.downlink_bandwidth >= FULL_SPEED &&
                     i_in_item.route_cost < r_path_cost_limit) begin
            n_st0.mode = MODE_RAW;
        end else begin
            n_st0.mode = MODE_SUM;
        end
    end

    // valid bits of the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NSTG; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s <= NSTG; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_vld <= r_vld[NSTG];
        end
    end

    // divider stages, one quotient bit each
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= n_st0;
            for (int s = 1; s <= NSTG; s++) begin
                r_st[s] <= div_step(r_st[s-1]);
            end
            r_out <= n_out;
        end
    end

    // sum of quotients and final selection
    always_comb begin
        qsum = {1'b0, r_st[NSTG].dq[0]} + {1'b0, r_st[NSTG].dq[1]}
             + {1'b0, r_st[NSTG].dq[2]};
        n_out.unreachable = 1'b0;
        case (r_st[NSTG].mode)
            MODE_INF: begin
                n_out.cost        = COST_INFINITE;
                n_out.unreachable = 1'b1;
            end
            MODE_CLASSIC: n_out.cost = {r_st[NSTG].route_cost, 31'd0};
            MODE_RAW:     n_out.cost = {31'd0, r_st[NSTG].route_cost};
            default:      n_out.cost = {7'd0, qsum};
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

FILE: tb/sv/gateway_cost_weigher_tb.sv
`timescale 1ns / 1ps
// gateway_cost_weigher_tb: self-checking bench for the gateway cost weigher,
// with a cost predictor, a bursty item driver, a stalling result monitor and apb writes
// depends on gcw_pkg and gateway_cost_weigher
module gateway_cost_weigher_tb;
    import gcw_pkg::*;

    localparam int LATENCY = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the cost registers
    logic [7:0]  cfg_etx_div;
    logic [7:0]  cfg_w_up;
    logic [7:0]  cfg_w_down;
    logic [7:0]  cfg_w_path;
    logic [31:0] cfg_pc_limit;

    t_in_item  pending_items[$];
    t_out_item expected_costs[$];
    int        mismatch_count;
    int        items_sent;
    int        costs_checked;
    int        inf_seen;
    int        burst_left;
    int        gap_left;
    int        hold_off;
    bit        stall_on;

    gateway_cost_weigher dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    // predict one gateway cost
    function automatic t_out_item weigh_gateway(t_in_item it);
        t_out_item   r;
        logic [63:0] c;
        logic [31:0] prod;
        logic [63:0] up_term;
        logic [63:0] down_term;
        logic [63:0] path_term;
        prod = it.route_cost * {24'd0, cfg_w_path};
        if (!it.link_up) begin
            c = 64'h7FFF_FFFF_FFFF_FFFF;
        end else if (cfg_etx_div == 8'd0) begin
            c = {32'd0, it.route_cost} << 31;
        end else if (it.uplink_bandwidth == 0 || it.downlink_bandwidth == 0) begin
            c = 64'h7FFF_FFFF_FFFF_FFFF;
        end else if (it.uplink_bandwidth >= FULL_SPEED && it.downlink_bandwidth >= FULL_SPEED
                     && it.route_cost < cfg_pc_limit) begin
            c = {32'd0, it.route_cost};
        end else begin
            up_term   = ((64'd1000 * cfg_w_up) << 23) / {32'd0, it.uplink_bandwidth};
            down_term = ((64'd1000 * cfg_w_down) << 23) / {32'd0, it.downlink_bandwidth};
            path_term = ({32'd0, prod} << 23) / {56'd0, cfg_etx_div};
            c = up_term + down_term + path_term;
        end
        r.cost        = c[62:0];
        r.unreachable = (c == 64'h7FFF_FFFF_FFFF_FFFF);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        mismatch_count++;
    endtask

    // apb write, only while idle
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ETX_DIVIDER:     cfg_etx_div  = val[7:0];
            REG_WEIGHT_UPLINK:   cfg_w_up     = val[7:0];
            REG_WEIGHT_DOWNLINK: cfg_w_down   = val[7:0];
            REG_WEIGHT_PATH:     cfg_w_path   = val[7:0];
            REG_PATH_COST_LIMIT: cfg_pc_limit = val;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [7:0] d, logic [7:0] u, logic [7:0] w,
                             logic [7:0] p, logic [31:0] lim);
        apb_write(REG_ETX_DIVIDER, {24'd0, d});
        apb_write(REG_WEIGHT_UPLINK, {24'd0, u});
        apb_write(REG_WEIGHT_DOWNLINK, {24'd0, w});
        apb_write(REG_WEIGHT_PATH, {24'd0, p});
        apb_write(REG_PATH_COST_LIMIT, lim);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_costs.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_bw();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom_range(320000000, 32'hFFFF_FFFF);
            2: return $urandom_range(1, 1000);
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.link_up            = ($urandom_range(0, 9) != 0);
        it.route_cost         = $urandom_range(0, 3) == 0 ? $urandom_range(0, 300) : $urandom;
        it.uplink_bandwidth   = rand_bw();
        it.downlink_bandwidth = rand_bw();
        return it;
    endfunction

    task automatic queue_item(logic up, logic [31:0] pc, logic [31:0] bu, logic [31:0] bd);
        t_in_item it;
        it.link_up            = up;
        it.route_cost         = pc;
        it.uplink_bandwidth   = bu;
        it.downlink_bandwidth = bd;
        pending_items.push_back(it);
    endtask

    // item driver: bursts and gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                expected_costs.push_back(weigh_gateway(i_in_item));
                items_sent++;
            end
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                i_in_item  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and stall pattern
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_costs.size() == 0) begin
                    report_mismatch("unexpected cost", {1'b0, o_out_item.cost}, 64'd0);
                end else begin
                    want = expected_costs.pop_front();
                    if (o_out_item.cost !== want.cost)
                        report_mismatch("cost", {1'b0, o_out_item.cost}, {1'b0, want.cost});
                    if (o_out_item.unreachable !== want.unreachable)
                        report_mismatch("unreachable", {63'd0, o_out_item.unreachable},
                                        {63'd0, want.unreachable});
                    if (want.unreachable) inf_seen++;
                end
                costs_checked++;
            end
            if (hold_off > 0) begin
                i_out_ready <= 1'b0;
                hold_off    <= hold_off - 1;
            end else if (stall_on) begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        int phase;
        mismatch_count = 0;
        items_sent     = 0;
        costs_checked  = 0;
        inf_seen       = 0;
        hold_off       = 0;
        stall_on       = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cfg_etx_div    = 8'd0;
        cfg_w_up       = 8'd1;
        cfg_w_down     = 8'd1;
        cfg_w_path     = 8'd1;
        cfg_pc_limit   = 32'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: classic mode at reset values, link down, zero bandwidth ignored
        queue_item(1'b0, 32'd5, 32'd1, 32'd1);
        queue_item(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0);
        queue_item(1'b1, 32'd0, 32'd7, 32'd9);
        wait_drained();

        // weighed mode: zero bandwidth, full speed below limit, wrapping product
        write_all(8'd1, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF);
        queue_item(1'b0, 32'd1, 32'd1, 32'd1);
        queue_item(1'b1, 32'd10, 32'd0, 32'd100);
        queue_item(1'b1, 32'd10, 32'd100, 32'd0);
        queue_item(1'b1, 32'd10, 32'd320000000, 32'd320000000);
        queue_item(1'b1, 32'd10, 32'd319999999, 32'd320000000);
        queue_item(1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(1'b1, 32'hFFFF_FFFF, 32'd1, 32'd1);
        queue_item(1'b1, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF);
        queue_item(1'b1, 32'd0, 32'd1, 32'd1);
        wait_drained();
        write_all(8'd255, 8'd0, 8'd0, 8'd0, 32'd0);
        queue_item(1'b1, 32'd10, 32'd320000000, 32'd320000000);
        queue_item(1'b1, 32'hFFFF_FFFF, 32'd1, 32'd1);
        queue_item(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        wait_drained();

        // random phases with new register settings
        for (phase = 0; phase < 6; phase++) begin
            if (phase == 5) write_all(8'd0, 8'd1, 8'd1, 8'd1, 32'd0);
            else write_all(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
                           8'($urandom), $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF);
            stall_on = (phase != 2);
            repeat (150) pending_items.push_back(rand_item());
            if (phase == 1) begin
                // long receiver hold-off while the sender keeps offering
                hold_off = 200;
            end
            wait_drained();
        end

        $display("covered %0d items and %0d checked costs, %0d unreachable",
                 items_sent, costs_checked, inf_seen);
        $display("register settings swept include classic mode and all extremes");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/gcw_pkg.sv
rtl/gateway_cost_weigher.sv
tb/sv/gateway_cost_weigher_tb.sv
